### rtl/core/cled_pkg.sv
package cled_pkg;

  localparam int unsigned DepthDefault = 128;

  localparam logic [7:0] ChNul  = 8'h00;
  localparam logic [7:0] ChEof  = 8'h04;
  localparam logic [7:0] ChBs   = 8'h08;
  localparam logic [7:0] ChNl   = 8'h0A;
  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChDump = 8'h10;
  localparam logic [7:0] ChKill = 8'h15;
  localparam logic [7:0] ChDel  = 8'h7F;

  typedef enum logic [1:0] {
    RdEmpty   = 2'd0,
    RdData    = 2'd1,
    RdNewline = 2'd2,
    RdEof     = 2'd3
  } read_status_e;

endpackage

### rtl/core/cled_ring.sv
module cled_ring #(
  parameter int unsigned DEPTH = cled_pkg::DepthDefault
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [7:0]               wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [7:0]               rd_data_o
);
  import cled_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_q;
  logic [7:0] byp_data_q;
  logic       byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  // A write to the address being read in the same cycle is forwarded.
  always_ff @(posedge clk_i) begin
    byp_q      <= wr_en_i && (wr_addr_i == rd_addr_i);
    byp_data_q <= wr_data_i;
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_data_q;

endmodule

### rtl/core/console_line_editor_unit.sv
// Each result is registered and presented the cycle after acceptance. Throughput:
// one transaction per cycle unless the output stalls; the ring has one write port
// and one read port that keeps the byte at the read index prefetched in a register.
// Reset clears the read, commit and edit indices and the result valid flag.
// The ring contents are not cleared; only written entries are ever read.
module console_line_editor_unit #(
  parameter int unsigned DEPTH = cled_pkg::DepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [7:0]            rx_char_i,
  input  logic                  read_started_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  echo_valid_o,
  output logic [7:0]            echo_char_o,
  output logic [7:0]            erase_count_o,
  output logic                  line_ready_o,
  output logic                  dump_request_o,
  output logic [1:0]            read_status_o,
  output logic [7:0]            read_char_o
);
  import cled_pkg::*;

  localparam int unsigned Span  = 2 * DEPTH;
  localparam int unsigned IdxW  = $clog2(Span);
  localparam int unsigned AddrW = $clog2(DEPTH);

  function automatic logic [IdxW-1:0] idx_next(input logic [IdxW-1:0] v);
    return (v == IdxW'(Span - 1)) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] idx_prev(input logic [IdxW-1:0] v);
    return (v == '0) ? IdxW'(Span - 1) : v - 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] idx_dist(input logic [IdxW-1:0] hi,
                                               input logic [IdxW-1:0] lo);
    logic [IdxW:0] diff;
    diff = {1'b0, hi} - {1'b0, lo};
    if (hi < lo) begin
      diff = diff + (IdxW + 1)'(Span);
    end
    return diff[IdxW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] to_addr(input logic [IdxW-1:0] v);
    logic [IdxW-1:0] a;
    a = (v >= IdxW'(DEPTH)) ? v - IdxW'(DEPTH) : v;
    return a[AddrW-1:0];
  endfunction

  logic [IdxW-1:0] read_idx_q, read_idx_d;
  logic [IdxW-1:0] commit_idx_q, commit_idx_d;
  logic [IdxW-1:0] edit_idx_q, edit_idx_d;

  logic            out_valid_q, out_valid_d;
  logic            echo_valid_q, echo_valid_d;
  logic [7:0]      echo_char_q, echo_char_d;
  logic [7:0]      erase_q, erase_d;
  logic            ready_q, ready_d;
  logic            dump_q, dump_d;
  read_status_e    status_q, status_d;
  logic [7:0]      rchar_q, rchar_d;

  logic            accept;
  logic            wr_en;
  logic [7:0]      wr_data;
  logic [7:0]      head_byte;
  logic [7:0]      ch;
  logic [IdxW-1:0] fill;
  logic [IdxW-1:0] pending;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign fill       = idx_dist(edit_idx_q, read_idx_q);
  assign pending    = idx_dist(edit_idx_q, commit_idx_q);

  always_comb begin
    read_idx_d   = read_idx_q;
    commit_idx_d = commit_idx_q;
    edit_idx_d   = edit_idx_q;
    echo_valid_d = 1'b0;
    echo_char_d  = 8'd0;
    erase_d      = 8'd0;
    ready_d      = 1'b0;
    dump_d       = 1'b0;
    status_d     = RdEmpty;
    rchar_d      = 8'd0;
    wr_en        = 1'b0;
    ch           = (rx_char_i == ChCr) ? ChNl : rx_char_i;
    wr_data      = ch;
    if (accept) begin
      if (!mode_i) begin
        if (rx_char_i == ChDump) begin
          dump_d = 1'b1;
        end else if (rx_char_i == ChKill) begin
          erase_d    = (32'(pending) > 32'd255) ? 8'd255 : 8'(pending);
          edit_idx_d = commit_idx_q;
        end else if (rx_char_i == ChBs || rx_char_i == ChDel) begin
          if (edit_idx_q != commit_idx_q) begin
            edit_idx_d = idx_prev(edit_idx_q);
            erase_d    = 8'd1;
          end
        end else if (rx_char_i != ChNul && fill < IdxW'(DEPTH)) begin
          echo_valid_d = 1'b1;
          echo_char_d  = ch;
          wr_en        = 1'b1;
          edit_idx_d   = idx_next(edit_idx_q);
          if (ch == ChNl || ch == ChEof || fill == IdxW'(DEPTH - 1)) begin
            commit_idx_d = idx_next(edit_idx_q);
            ready_d      = 1'b1;
          end
        end
      end else if (read_idx_q != commit_idx_q) begin
        if (head_byte == ChEof) begin
          status_d = RdEof;
          if (!read_started_i) begin
            read_idx_d = idx_next(read_idx_q);
          end
        end else begin
          read_idx_d = idx_next(read_idx_q);
          status_d   = (head_byte == ChNl) ? RdNewline : RdData;
          rchar_d    = head_byte;
        end
      end
    end
  end

  cled_ring #(
    .DEPTH(DEPTH)
  ) u_ring (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(to_addr(edit_idx_q)),
    .wr_data_i(wr_data),
    .rd_addr_i(to_addr(read_idx_d)),
    .rd_data_o(head_byte)
  );

  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_idx_q   <= '0;
      commit_idx_q <= '0;
      edit_idx_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      read_idx_q   <= read_idx_d;
      commit_idx_q <= commit_idx_d;
      edit_idx_q   <= edit_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      echo_valid_q <= echo_valid_d;
      echo_char_q  <= echo_char_d;
      erase_q      <= erase_d;
      ready_q      <= ready_d;
      dump_q       <= dump_d;
      status_q     <= status_d;
      rchar_q      <= rchar_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign echo_valid_o   = echo_valid_q;
  assign echo_char_o    = echo_char_q;
  assign erase_count_o  = erase_q;
  assign line_ready_o   = ready_q;
  assign dump_request_o = dump_q;
  assign read_status_o  = status_q;
  assign read_char_o    = rchar_q;

`ifndef SYNTHESIS
  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= IdxW'(DEPTH))
    else $error("ring holds more bytes than its depth");

  a_commit_between: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending <= fill)
    else $error("commit index lies outside the read to edit region");

  a_empty_read_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i && (read_idx_q == commit_idx_q)) |=> $stable(read_idx_q))
    else $error("read index moved on an empty ring");

  a_ready_with_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && line_ready_o) |-> echo_valid_o)
    else $error("line committed without an echoed byte");
`endif

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import cled_pkg::*;

  localparam int unsigned RingDepth = cled_pkg::DepthDefault;
  localparam int unsigned IdxW = $clog2(2 * RingDepth);
  localparam logic ModeRx = 1'b0;
  localparam logic ModeRead = 1'b1;
  localparam int unsigned RandomGoal = 400;
  localparam int unsigned MaxReports = 10;

  typedef logic [IdxW-1:0] ring_idx_t;

  typedef struct packed {
    logic         echo_valid;
    logic [7:0]   echo_char;
    logic [7:0]   erase_count;
    logic         line_ready;
    logic         dump_request;
    read_status_e read_status;
    logic [7:0]   read_char;
  } editor_result_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       mode;
  logic [7:0] rx_char;
  logic       read_started;
  logic       out_valid;
  logic       out_stall;
  logic       echo_valid;
  logic [7:0] echo_char;
  logic [7:0] erase_count;
  logic       line_ready;
  logic       dump_request;
  logic [1:0] read_status;
  logic [7:0] read_char;

  logic           sender_gaps;
  logic           sink_gaps;
  int unsigned    mismatch_count;
  int unsigned    useful_items;
  editor_result_t pending_results[$];

  logic [7:0] ring_shadow [RingDepth];
  ring_idx_t  rd_at;
  ring_idx_t  cm_at;
  ring_idx_t  ed_at;

  console_line_editor_unit u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .mode_i        (mode),
    .rx_char_i     (rx_char),
    .read_started_i(read_started),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .echo_valid_o  (echo_valid),
    .echo_char_o   (echo_char),
    .erase_count_o (erase_count),
    .line_ready_o  (line_ready),
    .dump_request_o(dump_request),
    .read_status_o (read_status),
    .read_char_o   (read_char)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

  function automatic editor_result_t predict_editor(logic m_in, logic [7:0] ch_in,
                                                    logic started_in);
    editor_result_t r;
    logic [7:0]     c;
    r = '0;
    if (m_in == ModeRx) begin
      if (ch_in == ChDump) begin
        r.dump_request = 1'b1;
      end else if (ch_in == ChKill) begin
        r.erase_count = 8'(ring_idx_t'(ed_at - cm_at));
        ed_at = cm_at;
      end else if (ch_in == ChBs || ch_in == ChDel) begin
        if (ed_at != cm_at) begin
          ed_at = ed_at - 1'b1;
          r.erase_count = 8'd1;
        end
      end else if (ch_in != ChNul && ring_idx_t'(ed_at - rd_at) < RingDepth) begin
        c = (ch_in == ChCr) ? ChNl : ch_in;
        r.echo_valid = 1'b1;
        r.echo_char = c;
        ring_shadow[ed_at[IdxW-2:0]] = c;
        ed_at = ed_at + 1'b1;
        if (c == ChNl || c == ChEof || ring_idx_t'(ed_at - rd_at) == RingDepth) begin
          cm_at = ed_at;
          r.line_ready = 1'b1;
        end
      end
    end else if (rd_at != cm_at) begin
      c = ring_shadow[rd_at[IdxW-2:0]];
      if (c == ChEof) begin
        r.read_status = RdEof;
        if (!started_in) rd_at = rd_at + 1'b1;
      end else begin
        rd_at = rd_at + 1'b1;
        r.read_status = (c == ChNl) ? RdNewline : RdData;
        r.read_char = c;
      end
    end
    return r;
  endfunction

  task automatic issue_transaction(input logic m_in, input logic [7:0] ch_in,
                                   input logic started_in);
    int unsigned    gap;
    editor_result_t exp_res;
    logic           stalled;
    gap = sender_gaps ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m_in;
    rx_char <= ch_in;
    read_started <= started_in;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    exp_res = predict_editor(m_in, ch_in, started_in);
    pending_results.push_back(exp_res);
    if (exp_res != '0) useful_items++;
  endtask

  task automatic key(input logic [7:0] ch_in);
    issue_transaction(ModeRx, ch_in, 1'($urandom_range(0, 1)));
  endtask

  task automatic pop(input logic started_in);
    issue_transaction(ModeRead, 8'($urandom_range(0, 255)), started_in);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                      : 8'($urandom_range(8'h20, 8'h7E));
    end while (c == ChNul || c == ChEof || c == ChBs || c == ChNl || c == ChCr ||
               c == ChDump || c == ChKill || c == ChDel);
    return c;
  endfunction

  task automatic note_mismatch(input string what, input editor_result_t exp_res,
                               input editor_result_t got);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("%s: expected echo %b/%h erase %0d ready %b dump %b status %0d char %h",
               what, exp_res.echo_valid, exp_res.echo_char, exp_res.erase_count,
               exp_res.line_ready, exp_res.dump_request, exp_res.read_status,
               exp_res.read_char);
      $display("%s: actual   echo %b/%h erase %0d ready %b dump %b status %0d char %h",
               what, got.echo_valid, got.echo_char, got.erase_count, got.line_ready,
               got.dump_request, got.read_status, got.read_char);
    end
  endtask

  initial begin
    int unsigned    hold;
    editor_result_t got;
    editor_result_t exp_res;
    logic           seen;
    out_stall = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      hold = sink_gaps ? $urandom_range(0, 13) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do begin
        @(negedge clk);
        seen = (out_valid === 1'b1);
        got.echo_valid = echo_valid;
        got.echo_char = echo_char;
        got.erase_count = erase_count;
        got.line_ready = line_ready;
        got.dump_request = dump_request;
        got.read_status = read_status_e'(read_status);
        got.read_char = read_char;
        @(posedge clk);
      end while (!seen);
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected transaction", '0, got);
      end else begin
        exp_res = pending_results.pop_front();
        if (got !== exp_res) note_mismatch("result mismatch", exp_res, got);
      end
    end
  end

  task automatic test_idle_reads();
    pop(1'b0);
    pop(1'b1);
    issue_transaction(ModeRead, 8'hFF, 1'b0);
    issue_transaction(ModeRead, 8'h00, 1'b1);
  endtask

  task automatic test_line_entry();
    sender_gaps = 1'b0;
    sink_gaps = 1'b0;
    key("a");
    key(ChCr);
    pop(1'b0);
    pop(1'b1);
    key(8'hFF);
    key(8'h80);
    key(ChNl);
    pop(1'b0);
    pop(1'b1);
    pop(1'b1);
    pop(1'b1);
    sender_gaps = 1'b1;
    sink_gaps = 1'b1;
  endtask

  task automatic test_editing_keys();
    key(ChDump);
    key(ChNul);
    key(ChBs);
    key(ChDel);
    key(ChKill);
    key("x");
    key("y");
    key("z");
    key(ChBs);
    key(ChDel);
    key("w");
    key(ChKill);
    key(ChNl);
    pop(1'b0);
    pop(1'b0);
  endtask

  task automatic test_end_of_file();
    key("q");
    key(ChEof);
    pop(1'b0);
    pop(1'b1);
    pop(1'b0);
    pop(1'b0);
    key(ChEof);
    pop(1'b1);
    pop(1'b0);
  endtask

  task automatic test_full_ring();
    drain_results();
    repeat (RingDepth + 2) key(plain_char());
    key(ChBs);
    key(ChKill);
    repeat (RingDepth / 2) pop(1'b1);
    repeat (RingDepth / 4) key(plain_char());
    key(ChCr);
    repeat (RingDepth + 2) pop(1'b1);
  endtask

  task automatic test_random_sessions();
    int unsigned goal;
    int unsigned len;
    int unsigned n;
    int unsigned pick;
    goal = useful_items + RandomGoal;
    while (useful_items < goal) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(5, 20)) begin
            issue_transaction(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
          end
        end
        1: drain_results();
        default: begin
          len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, RingDepth + 12)
                                             : $urandom_range(0, 24);
          for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) key($urandom_range(0, 1) ? ChBs : ChDel);
            else if (pick == 1 && $urandom_range(0, 3) == 0) key(ChKill);
            else if (pick == 2) key(ChDump);
            else if (pick == 3) key(8'($urandom_range(1, 255)));
            else key(plain_char());
          end
          pick = $urandom_range(0, 5);
          key(pick == 0 ? ChEof : (pick < 3 ? ChCr : ChNl));
          n = $urandom_range(0, len + 3);
          for (int k = 0; k < n; k++) begin
            pop(k > 0 ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 4) == 0));
          end
        end
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    mode = ModeRx;
    rx_char = ChNul;
    read_started = 1'b0;
    sender_gaps = 1'b1;
    sink_gaps = 1'b1;
    mismatch_count = 0;
    useful_items = 0;
    rd_at = '0;
    cm_at = '0;
    ed_at = '0;
    foreach (ring_shadow[i]) ring_shadow[i] = 8'h00;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_reads();
    test_line_entry();
    test_editing_keys();
    drain_results();
    test_end_of_file();
    test_full_ring();
    test_random_sessions();

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/cled_pkg.sv
rtl/core/cled_ring.sv
rtl/core/console_line_editor_unit.sv
bench/tb.sv
